// ----- rtl/core/nsts_pkg.sv -----
// types, constants and helper functions shared by the sum tree sampler
`timescale 1ns / 1ps

package nsts_pkg;

  localparam int SUM_W = 48;
  localparam int IDX_W = 10;
  localparam int END_W = 11;
  localparam int CFG_W = 11;

  localparam logic [CFG_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_READ   = 2'd1,
    CMD_RANGE  = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [IDX_W-1:0]   leaf_index;
    logic [END_W-1:0]   range_end;
    logic [SUM_W-1:0]   operand_value;
  } in_word_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum_value;
    logic [IDX_W-1:0]   found_index;
    logic [SUM_W-1:0]   total_sum;
    logic               error;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LEAF_RD,
    S_LEAF_WAIT,
    S_SET_RD,
    S_SET_WR,
    S_SET_DIG,
    S_PFX,
    S_SRCH,
    S_SRCH_EV,
    S_FIN,
    S_LOAD
  } state_t;

  // number of levels below the root for a given leaf count
  function automatic int tree_depth(input int cap, input int fan);
    int n;
    int d;
    n = 1;
    d = 0;
    while (n < cap) begin
      n = n * fan;
      d = d + 1;
    end
    return d;
  endfunction

  function automatic int pow_int(input int base, input int e);
    int p;
    p = 1;
    for (int k = 0; k < e; k++) begin
      p = p * base;
    end
    return p;
  endfunction

endpackage

// ----- rtl/core/nary_sum_tree_sampler_core.sv -----
// n-ary sum tree over leaf priorities: set, read, range sum and prefix-sum search
//
//   port group | dir | handshake            | word
//   in_        | in  | in_valid / in_ready   | in_word  (cmd, leaf_index, range_end, value)
//   out_       | out | out_valid / out_ready | out_word (sum, found, total, error)
//   cfg_       | in  | cfg_we, no wait       | cfg_wdata (active_size)
//
// one word at a time; every node access goes through the single ram port
// read: leaf read, then finish; set: leaf read, then a read and a write per node on the path while walking
// siblings to the child that holds the leaf; range sum: two passes over the path; search: one level at a time
// after reset a clearing pass writes every node (1365 nodes at the defaults)
// a finished word waits in the output register while the next word is accepted
`timescale 1ns / 1ps

module nary_sum_tree_sampler_core #(
  parameter int CAPACITY   = 1024,
  parameter int FANOUT     = 4,
  parameter int LEAF_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  nsts_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output nsts_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [nsts_pkg::CFG_W-1:0]     cfg_wdata
);

  import nsts_pkg::*;

  localparam int DEPTH  = tree_depth(CAPACITY, FANOUT);
  localparam int LAST   = pow_int(FANOUT, DEPTH);
  localparam int BOUND  = (LAST - 1) / (FANOUT - 1);
  localparam int NODES  = BOUND + LAST;
  localparam int ADDR_W = $clog2(NODES);
  localparam int R_W    = ($clog2(LAST + 1) > END_W) ? $clog2(LAST + 1) : END_W;
  localparam int EFF_W  = ($clog2(CAPACITY + 1) > CFG_W) ? $clog2(CAPACITY + 1) : CFG_W;
  localparam int CMP_W  = (EFF_W > ADDR_W) ? EFF_W : ADDR_W;
  localparam int LV_W   = $clog2(DEPTH + 1);
  localparam int J_W    = $clog2(FANOUT);
  localparam int RUN_W  = SUM_W + J_W;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     active_size_r, active_size_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [SUM_W-1:0]     val_r, val_nxt;
  logic [R_W-1:0]       rem_r, rem_nxt;
  logic [LV_W-1:0]      lv_r, lv_nxt;
  logic [J_W-1:0]       j_r, j_nxt;
  logic [ADDR_W-1:0]    cadr_r, cadr_nxt;
  logic [ADDR_W-1:0]    nadr_r, nadr_nxt;
  logic [SUM_W-1:0]     acc_r, acc_nxt;
  logic [SUM_W-1:0]     delta_r, delta_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic [SUM_W-1:0]     tgt_r, tgt_nxt;
  logic [IDX_W-1:0]     found_r, found_nxt;
  logic                 err_r, err_nxt;
  logic                 pass_r, pass_nxt;
  logic                 pend_r, pend_nxt;
  logic                 pend_sub_r, pend_sub_nxt;
  logic [SUM_W-1:0]     root_r, root_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [SUM_W-1:0]     ram_wdata;
  logic [SUM_W-1:0]     ram_rdata;

  logic [R_W-1:0]       w_tab [2**LV_W];
  logic [EFF_W-1:0]     eff;
  logic [EFF_W-1:0]     idx_e, rend_e;
  logic                 accept;
  logic                 err_in;
  logic                 empty_in;
  logic [ADDR_W-1:0]    leaf_adr;
  logic [R_W-1:0]       w_cur;
  logic                 take;
  logic                 last_j;
  logic                 bottom;
  logic                 pass_end;
  logic                 nadr_leaf;
  logic                 cadr_leaf;
  logic [RUN_W:0]       run_v;
  logic                 hit;
  logic [CMP_W-1:0]     fidx;
  logic [CMP_W-1:0]     eff_c;
  logic                 can_load;

  // weight of one child subtree, in leaves, for children of a node at each level
  for (genvar g = 0; g < 2**LV_W; g++) begin : g_wtab
    if (g < DEPTH) begin : g_used
      assign w_tab[g] = R_W'(pow_int(FANOUT, DEPTH - 1 - g));
    end else begin : g_unused
      assign w_tab[g] = '0;
    end
  end

  nsts_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign eff = (EFF_W'(active_size_r) < EFF_W'(CAPACITY)) ? EFF_W'(active_size_r)
                                                         : EFF_W'(CAPACITY);
  assign idx_e    = EFF_W'(in_word.leaf_index);
  assign rend_e   = EFF_W'(in_word.range_end);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign empty_in = (idx_e == rend_e);

  always_comb begin
    unique case (in_word.cmd)
      CMD_SET:    err_in = (idx_e >= eff) || ((LEAF_WIDTH < SUM_W) &&
                           ((in_word.operand_value >> LEAF_WIDTH) != '0));
      CMD_READ:   err_in = (idx_e >= eff);
      CMD_RANGE:  err_in = (rend_e > eff) || (idx_e > rend_e);
      CMD_SEARCH: err_in = 1'b0;
      default:    err_in = 1'b0;
    endcase
  end

  assign leaf_adr  = ADDR_W'(BOUND) + ADDR_W'(idx_r);
  assign w_cur     = w_tab[lv_r];
  assign take      = (rem_r >= w_cur);
  assign last_j    = (j_r == J_W'(FANOUT - 1));
  assign bottom    = (lv_r == LV_W'(DEPTH - 1));
  assign pass_end  = take ? last_j : bottom;
  assign nadr_leaf = (nadr_r >= ADDR_W'(BOUND));
  assign cadr_leaf = (cadr_r >= ADDR_W'(BOUND));
  assign run_v     = (RUN_W + 1)'(run_r) + (RUN_W + 1)'(ram_rdata);
  assign hit       = last_j || (run_v >= (RUN_W + 1)'(tgt_r));
  assign fidx      = CMP_W'(cadr_r - ADDR_W'(BOUND));
  assign eff_c     = CMP_W'(eff);
  assign can_load  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == ADDR_W'(NODES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_word.cmd)
            CMD_SET, CMD_READ: state_nxt = err_in ? S_FIN : S_LEAF_RD;
            CMD_RANGE:         state_nxt = (err_in || empty_in) ? S_FIN : S_PFX;
            CMD_SEARCH:        state_nxt = S_SRCH;
            default:           state_nxt = S_FIN;
          endcase
        end
      end
      S_LEAF_RD:   state_nxt = S_LEAF_WAIT;
      S_LEAF_WAIT: state_nxt = (cmd_r == CMD_READ) ? S_FIN : S_SET_RD;
      S_SET_RD:    state_nxt = S_SET_WR;
      S_SET_WR:    state_nxt = nadr_leaf ? S_FIN : S_SET_DIG;
      S_SET_DIG: begin
        if (!take) state_nxt = S_SET_RD;
      end
      S_PFX: begin
        if (pass_end && pass_r) state_nxt = S_FIN;
      end
      S_SRCH:    state_nxt = S_SRCH_EV;
      S_SRCH_EV: state_nxt = (hit && cadr_leaf) ? S_FIN : S_SRCH;
      S_FIN:     state_nxt = S_LOAD;
      S_LOAD: begin
        if (can_load) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    active_size_nxt = cfg_we ? cfg_wdata : active_size_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    lv_nxt        = lv_r;
    j_nxt         = j_r;
    cadr_nxt      = cadr_r;
    nadr_nxt      = nadr_r;
    delta_nxt     = delta_r;
    run_nxt       = run_r;
    tgt_nxt       = tgt_r;
    found_nxt     = found_r;
    err_nxt       = err_r;
    pass_nxt      = pass_r;
    pend_nxt      = 1'b0;
    pend_sub_nxt  = pend_sub_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = '0;

    // a read issued last cycle lands in the accumulator
    if (pend_r) begin
      acc_nxt = pend_sub_r ? (acc_r - ram_rdata) : (acc_r + ram_rdata);
    end else begin
      acc_nxt = acc_r;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_word.cmd;
          idx_nxt   = in_word.leaf_index;
          val_nxt   = in_word.operand_value;
          err_nxt   = err_in;
          acc_nxt   = '0;
          found_nxt = '0;
          lv_nxt    = '0;
          j_nxt     = '0;
          cadr_nxt  = ADDR_W'(1);
          nadr_nxt  = '0;
          pass_nxt  = 1'b0;
          run_nxt   = '0;
          tgt_nxt   = in_word.operand_value;
          rem_nxt   = (in_word.cmd == CMD_SET) ? R_W'(in_word.leaf_index)
                                               : R_W'(in_word.range_end);
        end
      end
      S_LEAF_RD: begin
        ram_addr = leaf_adr;
      end
      S_LEAF_WAIT: begin
        if (cmd_r == CMD_READ) begin
          acc_nxt = ram_rdata;
        end else begin
          delta_nxt = val_r - ram_rdata;
        end
      end
      S_SET_RD: begin
        ram_addr = nadr_r;
      end
      S_SET_WR: begin
        ram_we    = 1'b1;
        ram_addr  = nadr_r;
        ram_wdata = ram_rdata + delta_r;
        cadr_nxt  = ADDR_W'(nadr_r * FANOUT + 1);
      end
      S_SET_DIG: begin
        // walk to the child that holds the leaf, one sibling a cycle
        if (take) begin
          rem_nxt  = rem_r - w_cur;
          cadr_nxt = cadr_r + 1'b1;
        end else begin
          nadr_nxt = cadr_r;
          lv_nxt   = lv_r + 1'b1;
        end
      end
      S_PFX: begin
        // left siblings on the path are summed, the first pass adds, the second subtracts
        if (take) begin
          ram_addr     = cadr_r;
          pend_nxt     = 1'b1;
          pend_sub_nxt = pass_r;
          rem_nxt      = rem_r - w_cur;
          j_nxt        = j_r + 1'b1;
          cadr_nxt     = cadr_r + 1'b1;
        end else begin
          lv_nxt   = lv_r + 1'b1;
          j_nxt    = '0;
          cadr_nxt = ADDR_W'(cadr_r * FANOUT + 1);
        end
        if (pass_end) begin
          pass_nxt = 1'b1;
          rem_nxt  = R_W'(idx_r);
          lv_nxt   = '0;
          j_nxt    = '0;
          cadr_nxt = ADDR_W'(1);
        end
      end
      S_SRCH: begin
        ram_addr = cadr_r;
      end
      S_SRCH_EV: begin
        if (hit) begin
          tgt_nxt = ((RUN_W + 1)'(tgt_r) >= (RUN_W + 1)'(run_r)) ?
                    SUM_W'((RUN_W + 1)'(tgt_r) - (RUN_W + 1)'(run_r)) : '0;
          run_nxt  = '0;
          j_nxt    = '0;
          cadr_nxt = ADDR_W'(cadr_r * FANOUT + 1);
          if (fidx >= eff_c) begin
            found_nxt = (eff_c == '0) ? '0 : IDX_W'(eff_c - 1'b1);
          end else begin
            found_nxt = IDX_W'(fidx);
          end
        end else begin
          run_nxt  = RUN_W'(run_v);
          j_nxt    = j_r + 1'b1;
          cadr_nxt = cadr_r + 1'b1;
        end
      end
      S_FIN: begin
      end
      S_LOAD: begin
        if (can_load) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.sum_value   = err_r ? '0 : acc_r;
          out_word_nxt.found_index = (err_r || cmd_r != CMD_SEARCH) ? '0 : found_r;
          out_word_nxt.total_sum   = root_r;
          out_word_nxt.error       = err_r;
        end
      end
      default: begin
      end
    endcase

    // mirror of the root node
    root_nxt = (ram_we && ram_addr == '0) ? ram_wdata : root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      active_size_r <= ACTIVE_SIZE_RST;
      clr_r         <= '0;
      pend_r        <= 1'b0;
      root_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      active_size_r <= active_size_nxt;
      clr_r         <= clr_nxt;
      pend_r        <= pend_nxt;
      root_r        <= root_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    lv_r       <= lv_nxt;
    j_r        <= j_nxt;
    cadr_r     <= cadr_nxt;
    nadr_r     <= nadr_nxt;
    acc_r      <= acc_nxt;
    delta_r    <= delta_nxt;
    run_r      <= run_nxt;
    tgt_r      <= tgt_nxt;
    found_r    <= found_nxt;
    err_r      <= err_nxt;
    pass_r     <= pass_nxt;
    pend_sub_r <= pend_sub_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("word accepted during clearing pass");

  a_error_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.error) |->
      (out_word_r.sum_value == '0 && out_word_r.found_index == '0))
    else $error("error word carries a sum or index");

  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SET_WR) |-> ($past(state_r) == S_SET_RD))
    else $error("node write without its read");

  a_root_mirror_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_addr == '0) |=> $stable(root_r))
    else $error("root mirror changed without a root write");

endmodule

// ----- rtl/core/nsts_ram.sv -----
// single port synchronous ram with registered read
`timescale 1ns / 1ps

module nsts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1365
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
